### rtl/code_page_hash_histogram_top_assert.svh
// assertion macros for the code page hash histogram checker
// no dependencies
`ifndef CODE_PAGE_HASH_HISTOGRAM_TOP_ASSERT_SVH
`define CODE_PAGE_HASH_HISTOGRAM_TOP_ASSERT_SVH

// same-cycle implication
`define CPHH_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("cphh assertion failed");

// next-cycle implication
`define CPHH_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("cphh assertion failed");

`endif

### rtl/cphh_pkg.sv
// types and constants for the code page hash histogram
// no dependencies
package cphh_pkg;

  localparam int TABLE_SLOTS = 16384;
  localparam int PROBE_LIMIT = 64;
  localparam int PAGE_SHIFT  = 12;

  localparam int SLOT_W    = $clog2(TABLE_SLOTS);
  localparam int PROBE_W   = $clog2(PROBE_LIMIT + 1);
  localparam int KEY_W     = 20;
  localparam int SLOT_FW   = 14;
  localparam int PAY_W     = 64;

  localparam logic [31:0] MIX_K1 = 32'h7feb352d;
  localparam logic [31:0] MIX_K2 = 32'h846ca68b;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  localparam logic [1:0] ST_HIT  = 2'd0;
  localparam logic [1:0] ST_NEW  = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;
  localparam logic [1:0] ST_READ = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [31:0] pc;
    logic [13:0] slot_index;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] slot;
    logic [19:0] page_key;
    logic [31:0] hit_count;
    logic [31:0] last_pc;
  } result_t;

endpackage

### rtl/code_page_hash_histogram_top.sv
// code page hash histogram top level: sequencer, shared mixer unit, table rams
// depends on cphh_pkg and cphh_ram
//
// After reset the block sweeps the key table clear, one slot a cycle, with busy
// high. A record beat keeps busy high while it probes n slots (1 to 64): the
// states MUL1, XS2, MUL2 and XS3 run the hash through one shared multiplier and
// xor-shift unit, PRB issues the first table read, then one slot is checked each
// cycle in CHK through the registered ram read port. A read beat keeps busy high
// through RDA and RDC and clears the slot it reads. The result strobe done is
// high for one cycle, the cycle busy falls; the receiver cannot stall it.
module code_page_hash_histogram_top
  import cphh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_XS2   = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_XS3   = 4'd5;
  localparam logic [3:0] S_PRB   = 4'd6;
  localparam logic [3:0] S_CHK   = 4'd7;
  localparam logic [3:0] S_RDA   = 4'd8;
  localparam logic [3:0] S_RDC   = 4'd9;

  logic [3:0]         state;
  logic [SLOT_W-1:0]  s;
  logic [PROBE_W-1:0] probe;
  logic [31:0]        h;
  logic [KEY_W-1:0]   key;
  logic [31:0]        pc_r;

  logic [KEY_W-1:0]   new_key;
  logic [31:0]        key_ext;
  logic [31:0]        mul_k;
  logic [31:0]        prod;
  logic [4:0]         sh;
  logic [31:0]        xs;
  logic [SLOT_W-1:0]  s_inc;

  logic               key_we;
  logic [SLOT_W-1:0]  key_waddr;
  logic [KEY_W-1:0]   key_wdata;
  logic [KEY_W-1:0]   key_rdata;
  logic               pay_we;
  logic [PAY_W-1:0]   pay_wdata;
  logic [PAY_W-1:0]   pay_rdata;
  logic [SLOT_W-1:0]  rd_addr;
  logic [31:0]        cnt;
  logic [31:0]        cnt_inc;

  assign busy = (state != S_IDLE);

  assign new_key = KEY_W'(item.pc >> PAGE_SHIFT) | KEY_W'(1);
  assign key_ext = 32'(new_key);

  // shared mixer unit
  assign mul_k = (state == S_MUL1) ? MIX_K1 : MIX_K2;
  assign prod  = h * mul_k;
  assign sh    = (state == S_XS2) ? 5'd15 : 5'd16;
  assign xs    = h ^ (h >> sh);

  assign s_inc   = (s == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : s + 1'b1;
  assign cnt     = pay_rdata[63:32];
  assign cnt_inc = (cnt == '1) ? cnt : cnt + 32'd1;

  always_comb begin
    key_we    = 1'b0;
    key_waddr = s;
    key_wdata = '0;
    pay_we    = 1'b0;
    pay_wdata = {32'd1, pc_r};
    rd_addr   = s;
    unique case (state)
      S_CLEAR: begin
        key_we = 1'b1;
      end
      S_CHK: begin
        rd_addr = s_inc;
        if (key_rdata == '0) begin
          key_we    = 1'b1;
          key_wdata = key;
          pay_we    = 1'b1;
        end else if (key_rdata == key) begin
          pay_we    = 1'b1;
          pay_wdata = {cnt_inc, pc_r};
        end
      end
      S_RDC: begin
        key_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  cphh_ram #(.Width(KEY_W), .Depth(TABLE_SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (rd_addr),
    .rdata (key_rdata)
  );

  // count and last address, only read behind a nonzero key
  cphh_ram #(.Width(PAY_W), .Depth(TABLE_SLOTS)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (s),
    .wdata (pay_wdata),
    .raddr (rd_addr),
    .rdata (pay_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      s     <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          s <= s_inc;
          if (s == SLOT_W'(TABLE_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (item.cmd == CMD_READ) begin
              s     <= SLOT_W'(item.slot_index);
              state <= S_RDA;
            end else begin
              key   <= new_key;
              pc_r  <= item.pc;
              h     <= key_ext ^ (key_ext >> 16);
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          h     <= prod;
          state <= S_XS2;
        end
        S_XS2: begin
          h     <= xs;
          state <= S_MUL2;
        end
        S_MUL2: begin
          h     <= prod;
          state <= S_XS3;
        end
        S_XS3: begin
          s     <= xs[SLOT_W-1:0];
          probe <= '0;
          state <= S_PRB;
        end
        S_PRB: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (key_rdata == '0) begin
            done             <= 1'b1;
            result.status    <= ST_NEW;
            result.slot      <= SLOT_FW'(s);
            result.page_key  <= key;
            result.hit_count <= 32'd1;
            result.last_pc   <= pc_r;
            state            <= S_IDLE;
          end else if (key_rdata == key) begin
            done             <= 1'b1;
            result.status    <= ST_HIT;
            result.slot      <= SLOT_FW'(s);
            result.page_key  <= key;
            result.hit_count <= cnt_inc;
            result.last_pc   <= pc_r;
            state            <= S_IDLE;
          end else if (probe == PROBE_W'(PROBE_LIMIT - 1)) begin
            done             <= 1'b1;
            result.status    <= ST_DROP;
            result.slot      <= '0;
            result.page_key  <= '0;
            result.hit_count <= '0;
            result.last_pc   <= '0;
            state            <= S_IDLE;
          end else begin
            s     <= s_inc;
            probe <= probe + 1'b1;
          end
        end
        S_RDA: begin
          state <= S_RDC;
        end
        S_RDC: begin
          done          <= 1'b1;
          result.status <= ST_READ;
          result.slot   <= SLOT_FW'(s);
          if (key_rdata == '0) begin
            result.page_key  <= '0;
            result.hit_count <= '0;
            result.last_pc   <= '0;
          end else begin
            result.page_key  <= key_rdata;
            result.hit_count <= cnt;
            result.last_pc   <= pay_rdata[31:0];
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/cphh_ram.sv
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module cphh_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/cphh_checker.sv
// port-level checker for the code page hash histogram, bound to the top level
// depends on cphh_pkg and code_page_hash_histogram_top_assert.svh
`include "code_page_hash_histogram_top_assert.svh"

module cphh_checker
  import cphh_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  logic accept;
  logic drop_beat;
  logic drop_clear;
  logic new_beat;
  logic new_first;

  assign accept     = start && !busy;
  assign drop_beat  = done && (result.status == ST_DROP);
  assign drop_clear = (result.page_key == '0) && (result.hit_count == '0) &&
                      (result.slot == '0) && (result.last_pc == '0);
  assign new_beat   = done && (result.status == ST_NEW);
  assign new_first  = (result.hit_count == 32'd1) && result.page_key[0];

  `CPHH_ASSERT_NXT(a_clear_after_rst, clk, 1'b0, rst, busy && !done)
  `CPHH_ASSERT_NXT(a_beat_not_instant, clk, rst, accept, busy && !done)
  `CPHH_ASSERT_IMP(a_drop_zero, clk, rst, drop_beat, drop_clear)
  `CPHH_ASSERT_IMP(a_new_one, clk, rst, new_beat, new_first)

endmodule

bind code_page_hash_histogram_top cphh_checker u_cphh_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

### bench/cphh_tb_pkg.sv
// page histogram scoreboard: a table model that predicts each result and checks it
// depends on cphh_pkg
`timescale 1ns / 100ps
package cphh_tb_pkg;
  import cphh_pkg::*;

  function automatic logic [31:0] page_mix(input logic [31:0] v);
    logic [31:0] m;
    m = v ^ (v >> 16);
    m = m * MIX_K1;
    m = m ^ (m >> 15);
    m = m * MIX_K2;
    m = m ^ (m >> 16);
    return m;
  endfunction

  function automatic int unsigned home_slot(input logic [KEY_W-1:0] key);
    return page_mix(32'(key)) % TABLE_SLOTS;
  endfunction

  class histogram_scoreboard;
    bit [KEY_W-1:0] page_keys  [TABLE_SLOTS];
    bit [31:0]      hit_counts [TABLE_SLOTS];
    bit [31:0]      last_pcs   [TABLE_SLOTS];
    result_t        expected_q [$];
    int unsigned    errors;

    function void note_beat(item_t it);
      result_t          r;
      int unsigned      s;
      int unsigned      probe;
      logic [31:0]      page;
      logic [KEY_W-1:0] key;
      bit               placed;
      r = '0;
      if (it.cmd == CMD_READ) begin
        s = it.slot_index % TABLE_SLOTS;
        r.status = ST_READ;
        r.slot = 14'(s);
        if (page_keys[s] != '0) begin
          r.page_key = page_keys[s];
          r.hit_count = hit_counts[s];
          r.last_pc = last_pcs[s];
        end
        page_keys[s] = '0;
        hit_counts[s] = '0;
        last_pcs[s] = '0;
      end else begin
        page = it.pc >> PAGE_SHIFT;
        key = page[KEY_W-1:0] | 20'd1;
        s = home_slot(key);
        r.status = ST_DROP;
        placed = 1'b0;
        for (probe = 0; probe < PROBE_LIMIT && !placed; probe++) begin
          if (page_keys[s] == '0 || page_keys[s] == key) begin
            if (page_keys[s] == '0) begin
              r.status = ST_NEW;
              page_keys[s] = key;
              hit_counts[s] = 32'd1;
            end else begin
              r.status = ST_HIT;
              if (hit_counts[s] != '1) hit_counts[s]++;
            end
            last_pcs[s] = it.pc;
            r.slot = 14'(s);
            r.page_key = key;
            r.hit_count = hit_counts[s];
            r.last_pc = it.pc;
            placed = 1'b1;
          end else begin
            s = (s + 1) % TABLE_SLOTS;
          end
        end
      end
      expected_q = {expected_q, r};
    endfunction

    function void check_beat(result_t got);
      result_t want;
      bit      bad;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      bad = 1'b0;
      if (got.status !== want.status) begin
        bad = 1'b1;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.slot !== want.slot) begin
        bad = 1'b1;
        $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
      end
      if (got.page_key !== want.page_key) begin
        bad = 1'b1;
        $display("%0t: page_key expected %h actual %h", $time, want.page_key, got.page_key);
      end
      if (got.hit_count !== want.hit_count) begin
        bad = 1'b1;
        $display("%0t: hit_count expected %0d actual %0d", $time, want.hit_count,
                 got.hit_count);
      end
      if (got.last_pc !== want.last_pc) begin
        bad = 1'b1;
        $display("%0t: last_pc expected %h actual %h", $time, want.last_pc, got.last_pc);
      end
      if (bad) errors++;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

### bench/tb_top.sv
// top of the page histogram bench: clock, reset, beat driver, result monitor, watchdog
// depends on cphh_pkg, cphh_tb_pkg and code_page_hash_histogram_top
`timescale 1ns / 100ps
module tb_top;
  import cphh_pkg::*;
  import cphh_tb_pkg::*;

  localparam int IDLE_LIMIT   = 60000;
  localparam int RANDOM_ITEMS = 1080;
  localparam int POOL_PAGES   = 24;
  localparam int ODD_KEYS     = 1 << (KEY_W - 1);

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  logic    done;
  item_t   beat_in;
  result_t beat_out;

  histogram_scoreboard board;
  bit                  no_idle;
  logic [KEY_W-1:0]    page_pool [POOL_PAGES];

  code_page_hash_histogram_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (beat_in),
    .done   (done),
    .result (beat_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) board.check_beat(beat_out);
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || done === 1'b1) idle = 0;
      else idle++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic item_t record_beat(input logic [31:0] pc);
    item_t it;
    it.cmd = CMD_RECORD;
    it.pc = pc;
    it.slot_index = 14'($urandom);
    return it;
  endfunction

  function automatic item_t read_beat(input logic [13:0] slot);
    item_t it;
    it.cmd = CMD_READ;
    it.pc = $urandom;
    it.slot_index = slot;
    return it;
  endfunction

  // any address inside the page
  function automatic logic [31:0] page_pc(input logic [KEY_W-1:0] page);
    return (32'(page) << PAGE_SHIFT) | ($urandom % (1 << PAGE_SHIFT));
  endfunction

  task automatic send(input item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    beat_in <= it;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_beat(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // clear the probe window from base with reads, fill it with one key per home slot, then overflow it
  task automatic run_cluster(input int unsigned base);
    logic [KEY_W-1:0] fill [PROBE_LIMIT];
    bit               found [PROBE_LIMIT];
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] intruder;
    bit               got_intruder;
    int unsigned      r;
    int unsigned      j;
    int unsigned      off;
    int               left;
    foreach (found[i]) begin
      found[i] = 1'b0;
      fill[i] = '0;
    end
    intruder = '0;
    got_intruder = 1'b0;
    left = PROBE_LIMIT + 1;
    r = $urandom_range(0, ODD_KEYS - 1);
    for (j = 0; j < ODD_KEYS && left > 0; j++) begin
      key = KEY_W'((((r + j) % ODD_KEYS) << 1) | 1);
      off = (home_slot(key) + TABLE_SLOTS - base) % TABLE_SLOTS;
      if (off < PROBE_LIMIT && !found[off]) begin
        fill[off] = key;
        found[off] = 1'b1;
        left--;
      end else if (off == 0 && !got_intruder) begin
        intruder = key;
        got_intruder = 1'b1;
        left--;
      end
    end
    for (int i = 0; i < PROBE_LIMIT; i++) send(read_beat(14'((base + i) % TABLE_SLOTS)));
    for (int i = 0; i < PROBE_LIMIT; i++) send(record_beat(page_pc(fill[i])));
    send(record_beat(page_pc(intruder)));
    send(record_beat(page_pc(fill[PROBE_LIMIT-1])));
  endtask

  initial begin : stimulus
    int issued;
    int phase_len;
    int pick;
    board = new();
    rst <= 1'b1;
    start <= 1'b0;
    beat_in <= '0;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty reads, field extremes, hits, page folding onto one key, read and clear
    send(read_beat(14'd0));
    send(read_beat(14'h3fff));
    send(record_beat(32'h0000_0000));
    send(record_beat(32'hffff_ffff));
    send(record_beat(32'h0000_0fff));
    send(record_beat(32'h0000_1000));
    send(record_beat(32'hffff_f000));
    send(record_beat(32'haaaa_aaaa));
    send(record_beat(32'h5555_5555));
    send(read_beat(14'(home_slot(20'd1))));
    send(read_beat(14'(home_slot(20'd1))));
    send(record_beat(32'h0000_0abc));
    send(read_beat(14'h2aaa));
    send(read_beat(14'h1555));
    send(read_beat(14'(home_slot(20'hfffff))));
    drain();

    // probe limit, once across the wrap of the table
    run_cluster(TABLE_SLOTS - PROBE_LIMIT / 2);
    drain();
    no_idle = 1'b1;
    run_cluster($urandom_range(0, TABLE_SLOTS - 1));
    drain();

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 150);
      no_idle = ($urandom_range(0, 3) == 0);
      foreach (page_pool[i]) page_pool[i] = KEY_W'($urandom);
      for (int k = 0; k < phase_len && issued < RANDOM_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send(read_beat(14'(home_slot(page_pool[$urandom_range(0, POOL_PAGES - 1)] | 20'd1)
                             + $urandom_range(0, 2))));
        end else if (pick < 20) begin
          send(read_beat(14'($urandom)));
        end else if (pick < 75) begin
          send(record_beat(page_pc(page_pool[$urandom_range(0, POOL_PAGES - 1)])));
        end else begin
          send(record_beat($urandom));
        end
        issued++;
      end
      if ($urandom_range(0, 2) == 0) drain();
    end

    drain();
    repeat (80) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/cphh_pkg.sv
rtl/cphh_ram.sv
rtl/code_page_hash_histogram_top.sv
rtl/cphh_checker.sv
bench/cphh_tb_pkg.sv
bench/tb_top.sv
